/* rtl/tle_pkg.sv */
// Shared types and constants for the terminal line editor.
package tle_pkg;

   localparam int LEN_W = 5;

   localparam logic [7:0] KEY_NL    = 8'd10;
   localparam logic [7:0] KEY_ESC   = 8'd27;
   localparam logic [7:0] KEY_BS    = 8'd127;
   localparam logic [7:0] KEY_LBR   = 8'h5B;
   localparam logic [7:0] KEY_LEFT  = 8'h44;
   localparam logic [7:0] KEY_RIGHT = 8'h43;
   localparam logic [7:0] ECHO_BACK = 8'd8;
   localparam logic [7:0] ECHO_SP   = 8'h20;

   localparam logic [1:0] KIND_ECHO = 2'd0;
   localparam logic [1:0] KIND_LINE = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;

   localparam logic [1:0] PH_NORMAL = 2'd0;
   localparam logic [1:0] PH_ESC    = 2'd1;
   localparam logic [1:0] PH_CSI    = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_LEFT,
      S_RC_ESC,
      S_RC_BR,
      S_RC_C,
      S_NL_ECHO,
      S_DLV_CHK,
      S_DLV_EMIT,
      S_DONE,
      S_INS_CHK,
      S_INS_WR,
      S_INS_KEY,
      S_TAIL_CHK,
      S_TAIL_EMIT,
      S_BACK_CHK,
      S_BS_E1,
      S_BS_E2,
      S_BS_E3,
      S_BS_CHK,
      S_BS_WR,
      S_BS_SP,
      S_BS_BK
   } st_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_INC,
      IDX_DEC,
      IDX_ZERO,
      IDX_LEN,
      IDX_CUR,
      IDX_CUR_P1,
      IDX_CUR_M1
   } idx_op_type;

   typedef enum logic [1:0] {
      LEN_HOLD,
      LEN_INC,
      LEN_DEC,
      LEN_ZERO
   } len_op_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_INC,
      CUR_DEC,
      CUR_ZERO,
      CUR_LEN_P1
   } cur_op_type;

   typedef enum logic [1:0] {
      ADR_IDX,
      ADR_IDX_M1,
      ADR_IDX_P1,
      ADR_LEN
   } adr_sel_type;

   typedef enum logic [1:0] {
      SRC_CONST,
      SRC_KEY,
      SRC_RDATA
   } src_type;

   typedef struct packed {
      logic        key_load;
      idx_op_type  idx_op;
      len_op_type  len_op;
      cur_op_type  cur_op;
      logic        phase_wr;
      logic [1:0]  phase_val;
      logic        rd_en;
      adr_sel_type rd_sel;
      logic        wr_en;
      adr_sel_type wr_sel;
      src_type     wr_src;
      logic        emit_en;
      src_type     emit_src;
      logic [7:0]  emit_byte;
      logic [1:0]  emit_kind;
      logic        emit_last;
   } ctl_cmd_type;

   typedef struct packed {
      logic [7:0]       key;
      logic [LEN_W-1:0] len;
      logic [LEN_W-1:0] cur;
      logic [LEN_W-1:0] idx;
      logic             mode;
      logic [1:0]       phase;
      logic             out_free;
   } ctl_stat_type;

endpackage

/* rtl/tle_datapath.sv */
// Line editor datapath: line store, length, cursor, escape phase and output register.
module tle_datapath import tle_pkg::*; #(
   parameter int LINE_LEN = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   req_key_byte,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic         csr_edit_mode,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output logic [7:0]   rsp_out_byte,
   output logic [1:0]   rsp_out_kind,
   output logic         rsp_last_of_run,
   input  ctl_cmd_type  cmd,
   output ctl_stat_type stat
);

   localparam int AW = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;

   logic [7:0]       mem [LINE_LEN];
   logic [7:0]       rdata_ff;
   logic [7:0]       key_ff;
   logic             mode_ff;
   logic [1:0]       phase_ff, phase_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] cur_ff, cur_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff;
   logic [1:0]       rsp_kind_ff;
   logic             rsp_last_ff;
   logic [LEN_W-1:0] rd_full, wr_full;
   logic [AW-1:0]    rd_addr, wr_addr;
   logic [7:0]       wr_data, emit_data;

   always_comb begin
      unique case (cmd.rd_sel)
         ADR_IDX:    rd_full = idx_ff;
         ADR_IDX_M1: rd_full = idx_ff - LEN_W'(1);
         ADR_IDX_P1: rd_full = idx_ff + LEN_W'(1);
         ADR_LEN:    rd_full = len_ff;
         default:    rd_full = idx_ff;
      endcase
      unique case (cmd.wr_sel)
         ADR_IDX:    wr_full = idx_ff;
         ADR_IDX_M1: wr_full = idx_ff - LEN_W'(1);
         ADR_IDX_P1: wr_full = idx_ff + LEN_W'(1);
         ADR_LEN:    wr_full = len_ff;
         default:    wr_full = idx_ff;
      endcase
      rd_addr = rd_full[AW-1:0];
      wr_addr = wr_full[AW-1:0];
      wr_data = (cmd.wr_src == SRC_KEY) ? key_ff : rdata_ff;
      unique case (cmd.emit_src)
         SRC_KEY:   emit_data = key_ff;
         SRC_RDATA: emit_data = rdata_ff;
         default:   emit_data = cmd.emit_byte;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      unique case (cmd.idx_op)
         IDX_INC:    idx_in = idx_ff + LEN_W'(1);
         IDX_DEC:    idx_in = idx_ff - LEN_W'(1);
         IDX_ZERO:   idx_in = '0;
         IDX_LEN:    idx_in = len_ff;
         IDX_CUR:    idx_in = cur_ff;
         IDX_CUR_P1: idx_in = cur_ff + LEN_W'(1);
         IDX_CUR_M1: idx_in = cur_ff - LEN_W'(1);
         default:    idx_in = idx_ff;
      endcase
      unique case (cmd.len_op)
         LEN_INC:  len_in = len_ff + LEN_W'(1);
         LEN_DEC:  len_in = len_ff - LEN_W'(1);
         LEN_ZERO: len_in = '0;
         default:  len_in = len_ff;
      endcase
      unique case (cmd.cur_op)
         CUR_INC:    cur_in = cur_ff + LEN_W'(1);
         CUR_DEC:    cur_in = cur_ff - LEN_W'(1);
         CUR_ZERO:   cur_in = '0;
         CUR_LEN_P1: cur_in = len_ff + LEN_W'(1);
         default:    cur_in = cur_ff;
      endcase
      phase_in = cmd.phase_wr ? cmd.phase_val : phase_ff;
      if (cmd.emit_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         phase_ff     <= PH_NORMAL;
         len_ff       <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_edit_mode;
         end
         phase_ff     <= phase_in;
         len_ff       <= len_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.key_load) begin
         key_ff <= req_key_byte;
      end
      if (cmd.emit_en) begin
         rsp_byte_ff <= emit_data;
         rsp_kind_ff <= cmd.emit_kind;
         rsp_last_ff <= cmd.emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_out_kind    = rsp_kind_ff;
   assign rsp_last_of_run = rsp_last_ff;

   assign stat.key      = key_ff;
   assign stat.len      = len_ff;
   assign stat.cur      = cur_ff;
   assign stat.idx      = idx_ff;
   assign stat.mode     = mode_ff;
   assign stat.phase    = phase_ff;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

endmodule

/* rtl/tle_ctrl.sv */
// Line editor controller: decodes each key and sequences store shifts and echo output.
module tle_ctrl import tle_pkg::*; #(
   parameter int LINE_LEN = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ctl_stat_type stat,
   output ctl_cmd_type  cmd
);

   st_type state_ff, state_in;
   logic   flow_bs_ff, flow_bs_in;
   logic   full, is_nl, is_bs, is_esc, fr;
   logic   idx_lt_len;

   assign full       = (stat.len == LEN_W'(LINE_LEN));
   assign is_nl      = (stat.key == KEY_NL);
   assign is_bs      = (stat.key == KEY_BS);
   assign is_esc     = (stat.key == KEY_ESC);
   assign fr         = stat.out_free;
   assign idx_lt_len = (stat.idx < stat.len);
   assign req_ready  = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (!stat.mode) begin
               state_in = is_nl ? S_DLV_CHK : S_IDLE;
            end else if (stat.phase == PH_ESC) begin
               state_in = S_IDLE;
            end else if (stat.phase == PH_CSI) begin
               if (stat.key == KEY_LEFT && stat.cur != '0) begin
                  state_in = S_LEFT;
               end else if (stat.key == KEY_RIGHT && stat.cur < stat.len) begin
                  state_in = S_RC_ESC;
               end else begin
                  state_in = S_IDLE;
               end
            end else if (is_nl) begin
               state_in = S_NL_ECHO;
            end else if (is_bs) begin
               state_in = (stat.cur != '0) ? S_BS_E1 : S_IDLE;
            end else if (is_esc || full) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_INS_CHK;
            end
         end
         S_LEFT:      if (fr) state_in = S_IDLE;
         S_RC_ESC:    if (fr) state_in = S_RC_BR;
         S_RC_BR:     if (fr) state_in = S_RC_C;
         S_RC_C:      if (fr) state_in = S_IDLE;
         S_NL_ECHO:   if (fr) state_in = S_DLV_CHK;
         S_DLV_CHK:   state_in = idx_lt_len ? S_DLV_EMIT : S_DONE;
         S_DLV_EMIT:  if (fr) state_in = S_DLV_CHK;
         S_DONE:      if (fr) state_in = S_IDLE;
         S_INS_CHK:   state_in = (stat.idx == stat.cur) ? S_INS_KEY : S_INS_WR;
         S_INS_WR:    state_in = S_INS_CHK;
         S_INS_KEY:   if (fr) state_in = S_TAIL_CHK;
         S_TAIL_CHK: begin
            if (idx_lt_len) begin
               state_in = S_TAIL_EMIT;
            end else begin
               state_in = flow_bs_ff ? S_BS_SP : S_BACK_CHK;
            end
         end
         S_TAIL_EMIT: if (fr) state_in = S_TAIL_CHK;
         S_BACK_CHK:  if (!idx_lt_len) state_in = S_IDLE;
         S_BS_E1:     if (fr) state_in = S_BS_E2;
         S_BS_E2:     if (fr) state_in = S_BS_E3;
         S_BS_E3:     if (fr) state_in = S_BS_CHK;
         S_BS_CHK: begin
            state_in = ((stat.idx + LEN_W'(1)) < stat.len) ? S_BS_WR : S_TAIL_CHK;
         end
         S_BS_WR:     state_in = S_BS_CHK;
         S_BS_SP:     if (fr) state_in = S_BS_BK;
         S_BS_BK:     if (fr) state_in = S_BACK_CHK;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      flow_bs_in = flow_bs_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.key_load = req_valid;
         end
         S_DECODE: begin
            cmd.phase_wr  = 1'b1;
            cmd.phase_val = PH_NORMAL;
            if (!stat.mode) begin
               if (is_nl) begin
                  cmd.idx_op = IDX_ZERO;
               end else if (!full) begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_sel = ADR_LEN;
                  cmd.wr_src = SRC_KEY;
                  cmd.len_op = LEN_INC;
                  cmd.cur_op = CUR_LEN_P1;
               end
            end else if (stat.phase == PH_ESC) begin
               cmd.phase_val = (stat.key == KEY_LBR) ? PH_CSI : PH_NORMAL;
            end else if (stat.phase != PH_CSI) begin
               if (is_esc) begin
                  cmd.phase_val = PH_ESC;
               end else if (is_bs) begin
                  flow_bs_in = 1'b1;
               end else if (!is_nl) begin
                  cmd.idx_op = IDX_LEN;
                  flow_bs_in = 1'b0;
               end
            end
         end
         S_LEFT: begin
            cmd.emit_en   = fr;
            cmd.emit_byte = ECHO_BACK;
            cmd.emit_last = 1'b1;
            if (fr) cmd.cur_op = CUR_DEC;
         end
         S_RC_ESC: begin
            cmd.emit_en   = fr;
            cmd.emit_byte = KEY_ESC;
         end
         S_RC_BR: begin
            cmd.emit_en   = fr;
            cmd.emit_byte = KEY_LBR;
         end
         S_RC_C: begin
            cmd.emit_en   = fr;
            cmd.emit_byte = KEY_RIGHT;
            cmd.emit_last = 1'b1;
            if (fr) cmd.cur_op = CUR_INC;
         end
         S_NL_ECHO: begin
            cmd.emit_en   = fr;
            cmd.emit_byte = KEY_NL;
            cmd.idx_op    = IDX_ZERO;
         end
         S_DLV_CHK: begin
            cmd.rd_en  = idx_lt_len;
            cmd.rd_sel = ADR_IDX;
         end
         S_DLV_EMIT: begin
            cmd.emit_en   = fr;
            cmd.emit_src  = SRC_RDATA;
            cmd.emit_kind = KIND_LINE;
            if (fr) cmd.idx_op = IDX_INC;
         end
         S_DONE: begin
            cmd.emit_en   = fr;
            cmd.emit_byte = 8'd0;
            cmd.emit_kind = KIND_DONE;
            cmd.emit_last = 1'b1;
            if (fr) begin
               cmd.len_op = LEN_ZERO;
               cmd.cur_op = CUR_ZERO;
            end
         end
         S_INS_CHK: begin
            if (stat.idx == stat.cur) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = ADR_IDX;
               cmd.wr_src = SRC_KEY;
               cmd.len_op = LEN_INC;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ADR_IDX_M1;
            end
         end
         S_INS_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = ADR_IDX;
            cmd.wr_src = SRC_RDATA;
            cmd.idx_op = IDX_DEC;
         end
         S_INS_KEY: begin
            cmd.emit_en   = fr;
            cmd.emit_src  = SRC_KEY;
            cmd.emit_last = (stat.len == (stat.cur + LEN_W'(1)));
            if (fr) begin
               cmd.idx_op = IDX_CUR_P1;
               cmd.cur_op = CUR_INC;
            end
         end
         S_TAIL_CHK: begin
            if (idx_lt_len) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ADR_IDX;
            end else begin
               cmd.idx_op = IDX_CUR;
            end
         end
         S_TAIL_EMIT: begin
            cmd.emit_en  = fr;
            cmd.emit_src = SRC_RDATA;
            if (fr) cmd.idx_op = IDX_INC;
         end
         S_BACK_CHK: begin
            if (idx_lt_len) begin
               cmd.emit_en   = fr;
               cmd.emit_byte = ECHO_BACK;
               cmd.emit_last = ((stat.idx + LEN_W'(1)) == stat.len);
               if (fr) cmd.idx_op = IDX_INC;
            end
         end
         S_BS_E1, S_BS_E3: begin
            cmd.emit_en   = fr;
            cmd.emit_byte = ECHO_BACK;
            if (state_ff == S_BS_E3) cmd.idx_op = IDX_CUR_M1;
         end
         S_BS_E2, S_BS_SP: begin
            cmd.emit_en   = fr;
            cmd.emit_byte = ECHO_SP;
         end
         S_BS_CHK: begin
            if ((stat.idx + LEN_W'(1)) < stat.len) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ADR_IDX_P1;
            end else begin
               cmd.len_op = LEN_DEC;
               cmd.cur_op = CUR_DEC;
               cmd.idx_op = IDX_CUR_M1;
            end
         end
         S_BS_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = ADR_IDX;
            cmd.wr_src = SRC_RDATA;
            cmd.idx_op = IDX_INC;
         end
         S_BS_BK: begin
            cmd.emit_en   = fr;
            cmd.emit_byte = ECHO_BACK;
            cmd.emit_last = (stat.len == stat.cur);
            cmd.idx_op    = IDX_CUR;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         flow_bs_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         flow_bs_ff <= flow_bs_in;
      end
   end

endmodule

/* rtl/terminal_line_editor_unit.sv */
// Terminal line editor: one keyboard byte in, echo and delivered line bytes out.
// Keys are taken one at a time; req_ready is high only while no key is in work.
// A key passes an accept state and a decode state, then emits its results one by one;
// each stored byte shifted or tail byte redrawn takes a registered store read, then a
// write or emit, and each loop ends with one closing check. How long a key is in work
// is set by the line store, read and written in separate states, and the serial echo.
// Results leave through one output register, so a stalled rsp_ready stalls the key
// in work. csr_edit_mode is always ready and is meant to be written while idle.
module terminal_line_editor_unit import tle_pkg::*; #(
   parameter int LINE_LEN = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_key_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_out_kind,
   output logic       rsp_last_of_run,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_edit_mode
);

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   assign csr_ready = 1'b1;

   tle_ctrl #(.LINE_LEN(LINE_LEN)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tle_datapath #(.LINE_LEN(LINE_LEN)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_key_byte    (req_key_byte),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_edit_mode   (csr_edit_mode),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_last_of_run (rsp_last_of_run),
      .cmd             (cmd),
      .stat            (stat)
   );

   a_cur_in_line: assert property (@(posedge clock) disable iff (reset)
      stat.cur <= stat.len)
      else $error("cursor beyond line length");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      stat.len <= LEN_W'(LINE_LEN))
      else $error("line length beyond store size");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == KIND_DONE |-> rsp_last_of_run)
      else $error("done marker not flagged as last item");

   a_one_key: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new key taken while one is in work");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for terminal_line_editor_unit: key stream in, echo/line items checked.
`timescale 1ns / 100ps

module tb_top;
   import tle_pkg::*;

   localparam int LINE_LEN = 16;
   localparam int DRAIN_CYCLES = 4 * LINE_LEN + 40;

   typedef struct {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       last;
   } term_out_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_key_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_out_kind;
   logic       rsp_last_of_run;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_edit_mode = 1'b0;

   // shadow of the editor state
   logic [7:0] line_mem [0:LINE_LEN-1];
   int         line_len = 0;
   int         cur_pos = 0;
   logic [1:0] esc_ph = PH_NORMAL;
   logic       mode_edit = 1'b0;

   logic [7:0]   key_q [$];
   term_out_type term_out_q [$];
   term_out_type want_item;
   int           keys_queued = 0;
   int           keys_taken = 0;
   int           errors = 0;
   int           send_idle_pct = 38;
   int           recv_idle_pct = 45;

   terminal_line_editor_unit #(.LINE_LEN(LINE_LEN)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_key_byte(req_key_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_out_kind(rsp_out_kind),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_edit_mode(csr_edit_mode)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR t=%0t: %s", $realtime, msg);
      errors++;
   endtask

   task automatic add_out(input logic [7:0] b, input logic [1:0] k);
      term_out_type t;
      t.out_byte = b;
      t.kind = k;
      t.last = 1'b0;
      term_out_q.push_back(t);
   endtask

   task automatic deliver_line_out();
      int i;
      for (i = 0; i < line_len; i++) add_out(line_mem[i], KIND_LINE);
      add_out(8'd0, KIND_DONE);
      line_len = 0;
      cur_pos = 0;
   endtask

   task automatic predict_key(input logic [7:0] key);
      int i;
      int start;
      term_out_type t;
      start = term_out_q.size();
      if (esc_ph == 2'd3) esc_ph = PH_NORMAL;
      if (mode_edit) begin
         if (esc_ph == PH_ESC) begin
            esc_ph = (key == KEY_LBR) ? PH_CSI : PH_NORMAL;
         end else if (esc_ph == PH_CSI) begin
            esc_ph = PH_NORMAL;
            if (key == KEY_LEFT) begin
               if (cur_pos > 0) begin
                  add_out(ECHO_BACK, KIND_ECHO);
                  cur_pos--;
               end
            end else if (key == KEY_RIGHT) begin
               if (cur_pos < line_len) begin
                  add_out(KEY_ESC, KIND_ECHO);
                  add_out(KEY_LBR, KIND_ECHO);
                  add_out(KEY_RIGHT, KIND_ECHO);
                  cur_pos++;
               end
            end
         end else if (key == KEY_NL) begin
            add_out(KEY_NL, KIND_ECHO);
            deliver_line_out();
         end else if (key == KEY_BS) begin
            if (cur_pos != 0) begin
               add_out(ECHO_BACK, KIND_ECHO);
               add_out(ECHO_SP, KIND_ECHO);
               add_out(ECHO_BACK, KIND_ECHO);
               for (i = cur_pos - 1; i + 1 < line_len; i++) line_mem[i] = line_mem[i+1];
               line_len--;
               cur_pos--;
               for (i = cur_pos; i < line_len; i++) add_out(line_mem[i], KIND_ECHO);
               add_out(ECHO_SP, KIND_ECHO);
               add_out(ECHO_BACK, KIND_ECHO);
               for (i = cur_pos; i < line_len; i++) add_out(ECHO_BACK, KIND_ECHO);
            end
         end else if (key == KEY_ESC) begin
            esc_ph = PH_ESC;
         end else if (line_len < LINE_LEN) begin
            for (i = line_len; i > cur_pos; i--) line_mem[i] = line_mem[i-1];
            line_mem[cur_pos] = key;
            line_len++;
            add_out(key, KIND_ECHO);
            for (i = cur_pos + 1; i < line_len; i++) add_out(line_mem[i], KIND_ECHO);
            for (i = cur_pos + 1; i < line_len; i++) add_out(ECHO_BACK, KIND_ECHO);
            cur_pos++;
         end
      end else begin
         esc_ph = PH_NORMAL;
         if (key == KEY_NL) begin
            deliver_line_out();
         end else if (line_len < LINE_LEN) begin
            line_mem[line_len] = key;
            line_len++;
            cur_pos = line_len;
         end
      end
      if (term_out_q.size() > start) begin
         t = term_out_q.pop_back();
         t.last = 1'b1;
         term_out_q.push_back(t);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_key(req_key_byte);
            keys_taken++;
         end
         if (!req_valid || req_ready) begin
            if (key_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_key_byte <= key_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (term_out_q.size() == 0) begin
            report_mismatch($sformatf("unexpected item byte=%0d kind=%0d last=%0d",
               rsp_out_byte, rsp_out_kind, rsp_last_of_run));
         end else begin
            want_item = term_out_q.pop_front();
            if (rsp_out_byte !== want_item.out_byte)
               report_mismatch($sformatf("out_byte %0d, want %0d",
                  rsp_out_byte, want_item.out_byte));
            if (rsp_out_kind !== want_item.kind)
               report_mismatch($sformatf("out_kind %0d, want %0d",
                  rsp_out_kind, want_item.kind));
            if (rsp_last_of_run !== want_item.last)
               report_mismatch($sformatf("last_of_run %0d, want %0d",
                  rsp_last_of_run, want_item.last));
         end
      end
   end

   task automatic push_key(input logic [7:0] b);
      key_q.push_back(b);
      keys_queued++;
   endtask

   task automatic push_csi(input logic [7:0] b);
      push_key(KEY_ESC);
      push_key(KEY_LBR);
      push_key(b);
   endtask

   // one line of edits ended by a newline; returns the number of keys pushed
   task automatic push_line(output int n);
      int len;
      int j;
      int r;
      n = keys_queued;
      len = ($urandom_range(3) == 0) ? $urandom_range(14, 22) : $urandom_range(0, 10);
      for (j = 0; j < len; j++) begin
         r = $urandom_range(99);
         if (r < 55) push_key(8'($urandom_range(32, 126)));
         else if (r < 65) push_key(KEY_BS);
         else if (r < 75) push_csi(KEY_LEFT);
         else if (r < 85) push_csi(KEY_RIGHT);
         else if (r < 90) push_key(8'($urandom_range(255)));
         else if (r < 95) begin
            push_key(KEY_ESC);
            push_key(8'($urandom_range(255)));
         end else push_csi(8'($urandom_range(255)));
      end
      push_key(KEY_NL);
      n = keys_queued - n;
   endtask

   task automatic wait_drained();
      while (keys_taken != keys_queued || term_out_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_edit_mode <= v;
      do @(posedge clock); while (!csr_ready);
      mode_edit = v;
      csr_valid <= 1'b0;
   endtask

   initial begin
      int seg;
      int cnt;
      int n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      write_mode(1'b1);
      push_key(KEY_BS);
      push_csi(KEY_LEFT);
      push_csi(KEY_RIGHT);
      push_key(8'h00);
      push_key(8'hFF);
      push_csi(KEY_LEFT);
      push_key("x");
      push_key(KEY_BS);
      push_csi(KEY_RIGHT);
      push_key(KEY_ESC);
      push_key("q");
      push_csi(KEY_NL);
      push_key(KEY_NL);
      wait_drained();

      write_mode(1'b0);
      push_key(KEY_ESC);
      push_key(KEY_BS);
      push_key("z");
      push_key(KEY_NL);
      wait_drained();

      for (seg = 0; seg < 6; seg++) begin
         case (seg / 2)
            0: begin
               send_idle_pct = 38;
               recv_idle_pct = 45;
            end
            1: begin
               send_idle_pct = 45;
               recv_idle_pct = 38;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         write_mode((seg % 2 == 0) ? 1'b1 : 1'b0);
         cnt = 0;
         while (cnt < ((seg % 2 == 0) ? 70 : 30)) begin
            push_line(n);
            cnt += n;
         end
         wait_drained();
      end

      if (errors == 0)
         $display("terminal_line_editor_unit: match");
      else
         $display("terminal_line_editor_unit: mismatch");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("terminal_line_editor_unit: mismatch");
      $finish;
   end

endmodule
